@@ design/dlf_pkg.sv @@
// Shared character codes, constants and status bundle for the decimal literal parser.
package dlf_pkg;

  // ASCII codes the parser recognizes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Decimal radix and the largest plain byte value
  localparam logic [3:0] RADIX    = 4'd10;
  localparam logic [7:0] BYTE_MAX = 8'd255;

  // Per-literal status flags passed from the accumulator to the result stage
  typedef struct packed {
    logic minus;           // first character was '-'
    logic bad_syntax;      // literal is not well formed
    logic overflowed;      // integer magnitude clamped
    logic non_digit_seen;  // some character was not a digit
  } flags_t;

endpackage

@@ design/dlf_accum.sv @@
// Per-literal accumulator: syntax tracking, integer and fraction sums.
module dlf_accum #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           character,
  input  logic                 last_char,
  output logic [INT_BITS-2:0]  int_next,
  output logic [FRAC_BITS-1:0] frac_next,
  output dlf_pkg::flags_t      flags_next
);

  localparam int IW    = INT_BITS - 1;
  localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam logic [IW-1:0] INT_LIM = {IW{1'b1}};

  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_GAP,
    PH_FRAC
  } phase_t;

  phase_t               phase, phase_next;
  logic [IW-1:0]        int_sum;
  logic [FRAC_BITS-1:0] frac_sum;
  logic [CNT_W-1:0]     frac_cnt, frac_cnt_next;
  logic                 stopped, stopped_next;
  dlf_pkg::flags_t      flags;

  // Character classes
  logic       is_digit, is_dot, is_plus, is_minus;
  logic [7:0] char_off;
  logic [3:0] digit_val;

  assign is_digit  = character inside {[dlf_pkg::CH_ZERO:dlf_pkg::CH_NINE]};
  assign is_dot    = (character == dlf_pkg::CH_DOT);
  assign is_plus   = (character == dlf_pkg::CH_PLUS);
  assign is_minus  = (character == dlf_pkg::CH_MINUS);
  assign char_off  = character - dlf_pkg::CH_ZERO;
  assign digit_val = is_digit ? char_off[3:0] : 4'd0;

  // Integer step: sum*10 + d, clamp when any bit above the limit width is set
  logic [IW+3:0] int_step;
  logic          int_ovf;

  assign int_step = (IW+4)'(int_sum) * (IW+4)'(dlf_pkg::RADIX) + (IW+4)'(digit_val);
  assign int_ovf  = |int_step[IW+3:IW];

  // Fraction weights floor(2^FRAC_BITS / 10^(k+1)) for entry k, worked out at elaboration
  logic [FRAC_BITS-1:0] weight_tab [MAX_FRAC_DIGITS];

  for (genvar k = 0; k < MAX_FRAC_DIGITS; k++) begin : g_wt
    localparam longint unsigned POW = 64'd10 ** (k + 1);
    localparam logic [63:0] WT = (64'd1 << FRAC_BITS) / POW;
    assign weight_tab[k] = WT[FRAC_BITS-1:0];
  end

  logic [FRAC_BITS-1:0] weight;
  logic [FRAC_BITS+3:0] frac_prod;
  logic                 frac_room;

  always_comb begin
    weight = '0;
    for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
      if (frac_cnt == CNT_W'(k)) weight = weight_tab[k];
    end
  end

  assign frac_prod = (FRAC_BITS+4)'(digit_val) * (FRAC_BITS+4)'(weight);
  assign frac_room = (frac_cnt < CNT_W'(MAX_FRAC_DIGITS));

  // Next state for the current character
  always_comb begin
    phase_next     = phase;
    int_next       = int_sum;
    frac_next      = frac_sum;
    frac_cnt_next  = frac_cnt;
    stopped_next   = stopped;
    flags_next     = flags;
    flags_next.non_digit_seen = flags.non_digit_seen | ~is_digit;

    case (phase)
      PH_START: begin
        flags_next.minus = is_minus;
        if (is_plus || is_minus) begin
          phase_next = PH_INT;
        end else if (is_digit) begin
          int_next   = int_ovf ? INT_LIM : int_step[IW-1:0];
          flags_next.overflowed = flags.overflowed | int_ovf;
          phase_next = PH_INT;
        end else if (is_dot) begin
          phase_next = PH_FRAC;
          if (last_char) flags_next.bad_syntax = 1'b1;
        end else begin
          flags_next.bad_syntax = 1'b1;
          phase_next = PH_GAP;
        end
      end
      default: begin
        if (is_digit) begin
          if (phase == PH_INT) begin
            int_next = int_ovf ? INT_LIM : int_step[IW-1:0];
            flags_next.overflowed = flags.overflowed | int_ovf;
          end else if (phase == PH_FRAC && !stopped && frac_room) begin
            frac_next     = frac_sum + frac_prod[FRAC_BITS-1:0];
            frac_cnt_next = frac_cnt + CNT_W'(1);
          end
        end else if (is_dot) begin
          if (phase == PH_FRAC) begin
            flags_next.bad_syntax = 1'b1;
            stopped_next = 1'b1;
          end else begin
            phase_next = PH_FRAC;
            if (last_char) flags_next.bad_syntax = 1'b1;
          end
        end else begin
          flags_next.bad_syntax = 1'b1;
          if (phase == PH_INT) phase_next = PH_GAP;
          else if (phase == PH_FRAC) stopped_next = 1'b1;
        end
      end
    endcase
  end

  // State registers; the last character returns to the start of a literal
  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      phase    <= PH_START;
      int_sum  <= '0;
      frac_sum <= '0;
      frac_cnt <= '0;
      stopped  <= 1'b0;
      flags    <= '0;
    end else if (step) begin
      phase    <= phase_next;
      int_sum  <= int_next;
      frac_sum <= frac_next;
      frac_cnt <= frac_cnt_next;
      stopped  <= stopped_next;
      flags    <= flags_next;
    end
  end

endmodule

@@ design/dlf_result.sv @@
// Result stage: signed Q value, range flags and the output register.
module dlf_result #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 result_stall,
  input  logic [INT_BITS-2:0]  int_sum,
  input  logic [FRAC_BITS-1:0] frac_sum,
  input  dlf_pkg::flags_t      flags,
  output logic                 result_valid,
  output logic signed [31:0]   value,
  output logic                 well_formed,
  output logic                 saturated,
  output logic                 no_minus,
  output logic                 unit_range,
  output logic                 byte_value
);

  localparam int IW = INT_BITS - 1;
  localparam int MW = IW + FRAC_BITS;
  localparam int CW = (IW > 8) ? IW : 8;

  // Magnitude low word; fraction sum stays below 2^FRAC_BITS so fields concatenate
  logic [MW+31:0] mag_ext;
  logic [31:0]    mag_lo;
  logic [31:0]    val_lo;

  assign mag_ext = {32'd0, int_sum, frac_sum};
  assign mag_lo  = mag_ext[31:0];
  assign val_lo  = flags.minus ? (~mag_lo + 32'd1) : mag_lo;

  // |value| <= 1 only for zero integer part, or exactly one with no fraction
  logic unit_next;
  assign unit_next = (int_sum == '0) || ((int_sum == IW'(1)) && (frac_sum == '0));

  // Plain byte check on the integer part
  logic [CW-1:0] int_cmp;
  logic          byte_next;
  assign int_cmp   = CW'(int_sum);
  assign byte_next = ~flags.non_digit_seen & ~flags.overflowed &
                     (int_cmp <= CW'(dlf_pkg::BYTE_MAX));

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      value       <= $signed(val_lo);
      well_formed <= ~flags.bad_syntax;
      saturated   <= flags.overflowed;
      no_minus    <= ~flags.minus;
      unit_range  <= unit_next;
      byte_value  <= byte_next;
    end
  end

endmodule

@@ design/decimal_literal_to_fixed_unit.sv @@
// Top level: decimal literal character stream to signed fixed point.
//
// Usage: feed one ASCII character per request on the char channel
// (char_valid/char_stall, fields character and last_char); last_char marks
// the final character of a literal. One request on the result channel
// (result_valid/result_stall) follows each literal: value in signed
// Q(INT_BITS).(FRAC_BITS) (low 32 bits), well_formed, saturated, no_minus,
// unit_range and byte_value.
// Throughput: one character per cycle unless a held result blocks a last
// character. Each character is captured in an input register and folded
// into the running sums by combinational logic (one constant multiply for
// the integer part, one table multiply-add for the fraction part). The
// output register loads the result when the last character is folded in.
// Stall: a held result blocks only the next last character; ordinary
// characters keep flowing into the accumulator while the result waits.
// Reset: clears the input and output valid flags and returns the parser to
// the start of a literal; no clearing sweep is needed.
module decimal_literal_to_fixed_unit #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         character,
  input  logic               last_char,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic               well_formed,
  output logic               saturated,
  output logic               no_minus,
  output logic               unit_range,
  output logic               byte_value
);

  // Input register
  logic       in_full;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_free;
  logic       step;

  assign out_free   = ~result_valid | ~result_stall;
  assign step       = in_full & (~in_last | out_free);
  assign char_stall = in_full & ~step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_valid && !char_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
    if (char_valid && !char_stall) begin
      in_char <= character;
      in_last <= last_char;
    end
  end

  // Accumulator
  logic [INT_BITS-2:0]  int_next;
  logic [FRAC_BITS-1:0] frac_next;
  dlf_pkg::flags_t      flags_next;

  dlf_accum #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .character  (in_char),
    .last_char  (in_last),
    .int_next   (int_next),
    .frac_next  (frac_next),
    .flags_next (flags_next)
  );

  // Result formatting and output register
  dlf_result #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (step & in_last),
    .result_stall (result_stall),
    .int_sum      (int_next),
    .frac_sum     (frac_next),
    .flags        (flags_next),
    .result_valid (result_valid),
    .value        (value),
    .well_formed  (well_formed),
    .saturated    (saturated),
    .no_minus     (no_minus),
    .unit_range   (unit_range),
    .byte_value   (byte_value)
  );

endmodule

@@ tb/testbench.sv @@
// Testbench for decimal_literal_to_fixed_unit: directed and random literals, Q16.16.
module testbench;

  localparam int INT_BITS        = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 8;

  localparam longint unsigned INT_LIMIT = (64'd1 << (INT_BITS - 1)) - 64'd1;
  localparam longint          ONE_FIXED = 64'sd1 << FRAC_BITS;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW   = 8'h00;
  localparam logic [7:0] CH_HIGH  = 8'hFF;

  localparam int RANDOM_ITEMS     = 1000;
  localparam int PAUSE_AT_LITERAL = 100;
  localparam int HOLD_AT_RESULT   = 25;
  localparam int LONG_HOLD        = 300;
  localparam int TAIL_CYCLES      = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic               well_formed;
    logic               saturated;
    logic               no_minus;
    logic               unit_range;
    logic               byte_value;
  } fixed_result_t;

  // One directed character; the result is typed in only on rows marked typed
  typedef struct packed {
    logic [7:0]    ch;
    logic          last;
    logic          typed;
    fixed_result_t res;
  } char_row_t;

  typedef enum logic [1:0] {PH_START, PH_INT, PH_GAP, PH_FRAC} lit_phase_t;

  localparam fixed_result_t NONE = '0;
  localparam int DIRECTED_LEN = 24;
  localparam char_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    // lone zero: a plain byte
    '{dlf_pkg::CH_ZERO,        1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}},
    // sign alone is well formed with value zero
    '{dlf_pkg::CH_PLUS,        1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
    // lone dot
    '{dlf_pkg::CH_DOT,         1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    // 255: top of the byte range
    '{dlf_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, '{32'h00FF_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
    // 3.25, checked by the predictor
    '{dlf_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_DOT,         1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd5, 1'b1, 1'b0, NONE},
    // -99999.5: integer clamps, fraction still added, whole thing negated
    '{dlf_pkg::CH_MINUS,       1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd9, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_DOT,         1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, '{32'h8000_8003, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    // trailing dot: value kept, syntax bad
    '{dlf_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_DOT,         1'b1, 1'b1, '{32'h0001_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    // leading whitespace is not skipped
    '{CH_SPACE,                1'b0, 1'b0, NONE},
    '{dlf_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
    // extremes of the character field
    '{CH_LOW,                  1'b0, 1'b0, NONE},
    '{CH_HIGH,                 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  logic [7:0]         character = '0;
  logic               last_char = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] value;
  logic               well_formed;
  logic               saturated;
  logic               no_minus;
  logic               unit_range;
  logic               byte_value;

  decimal_literal_to_fixed_unit #(
    .INT_BITS(INT_BITS),
    .FRAC_BITS(FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .character(character),
    .last_char(last_char),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value(value),
    .well_formed(well_formed),
    .saturated(saturated),
    .no_minus(no_minus),
    .unit_range(unit_range),
    .byte_value(byte_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state of the literal in progress
  lit_phase_t      ph;
  logic            neg_sign, first_minus, bad_syntax, overflowed;
  logic            non_digit_seen, frac_stopped;
  longint unsigned int_mag, frac_acc;
  int unsigned     frac_count;

  fixed_result_t pending_results[$];
  logic [7:0]    lit_chars[$];

  int chars_sent, literals_sent, results_seen, failures;
  int wf_seen, sat_seen, unit_seen, byte_seen;

  function automatic void clear_literal();
    ph             = PH_START;
    neg_sign       = 1'b0;
    first_minus    = 1'b0;
    bad_syntax     = 1'b0;
    overflowed     = 1'b0;
    non_digit_seen = 1'b0;
    frac_stopped   = 1'b0;
    int_mag        = 0;
    frac_acc       = 0;
    frac_count     = 0;
  endfunction

  // Integer part saturates at the largest positive magnitude
  function automatic void add_int_digit(longint unsigned d);
    longint unsigned n;
    n = int_mag * dlf_pkg::RADIX + d;
    if (n > INT_LIMIT) begin
      int_mag    = INT_LIMIT;
      overflowed = 1'b1;
    end else begin
      int_mag = n;
    end
  endfunction

  // Digit k of the fraction weighs floor(2^FRAC_BITS / 10^k)
  function automatic void add_frac_digit(longint unsigned d);
    longint unsigned scale;
    int k;
    if (frac_count < MAX_FRAC_DIGITS && frac_count < 12) begin
      scale = dlf_pkg::RADIX;
      for (k = 0; k < frac_count; k++) scale = scale * dlf_pkg::RADIX;
      frac_acc   = frac_acc + d * ((64'd1 << FRAC_BITS) / scale);
      frac_count = frac_count + 1;
    end
  endfunction

  // Folds one character into the literal; returns 1 with the result on the last one
  function automatic logic parse_char(input logic [7:0] c, input logic last,
                                      output fixed_result_t res);
    logic            digit;
    longint unsigned d, mag;
    longint          v;
    digit = (c >= dlf_pkg::CH_ZERO) && (c <= dlf_pkg::CH_NINE);
    d     = digit ? 64'(c - dlf_pkg::CH_ZERO) : 64'd0;
    res   = '0;
    if (!digit) non_digit_seen = 1'b1;

    if (ph == PH_START) begin
      first_minus = (c == dlf_pkg::CH_MINUS);
      if (c == dlf_pkg::CH_PLUS || c == dlf_pkg::CH_MINUS) begin
        neg_sign = first_minus;
        ph = PH_INT;
      end else if (digit) begin
        add_int_digit(d);
        ph = PH_INT;
      end else if (c == dlf_pkg::CH_DOT) begin
        ph = PH_FRAC;
        if (last) bad_syntax = 1'b1;
      end else begin
        bad_syntax = 1'b1;
        ph = PH_GAP;
      end
    end else if (digit) begin
      if (ph == PH_INT) add_int_digit(d);
      else if (ph == PH_FRAC && !frac_stopped) add_frac_digit(d);
    end else if (c == dlf_pkg::CH_DOT) begin
      // a second dot ends the fraction
      if (ph == PH_FRAC) begin
        bad_syntax   = 1'b1;
        frac_stopped = 1'b1;
      end else begin
        ph = PH_FRAC;
        if (last) bad_syntax = 1'b1;
      end
    end else begin
      bad_syntax = 1'b1;
      if (ph == PH_INT) ph = PH_GAP;
      else if (ph == PH_FRAC) frac_stopped = 1'b1;
    end

    if (!last) return 1'b0;

    mag = (int_mag << FRAC_BITS) + frac_acc;
    v   = neg_sign ? -longint'(mag) : longint'(mag);
    res.value       = v[31:0];
    res.well_formed = !bad_syntax;
    res.saturated   = overflowed;
    res.no_minus    = !first_minus;
    res.unit_range  = (v >= -ONE_FIXED) && (v <= ONE_FIXED);
    res.byte_value  = !non_digit_seen && !overflowed && (int_mag <= dlf_pkg::BYTE_MAX);
    clear_literal();
    return 1'b1;
  endfunction

  // Offers one character after a gap and waits for the request to be taken
  task automatic offer_char(input logic [7:0] c, input logic last, input int gap,
                            input logic typed, input fixed_result_t typed_res);
    fixed_result_t predicted;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    character  <= c;
    last_char  <= last;
    do @(posedge clk); while (char_stall);
    chars_sent++;
    if (parse_char(c, last, predicted)) begin
      pending_results.push_back(typed ? typed_res : predicted);
      literals_sent++;
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    failures++;
  endtask

  task automatic check_result();
    fixed_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing expected, actual value %h", $time, value);
      failures++;
      return;
    end
    want = pending_results.pop_front();
    if (value !== want.value) report_field("value", want.value, value);
    if (well_formed !== want.well_formed)
      report_field("well_formed", 32'(want.well_formed), 32'(well_formed));
    if (saturated !== want.saturated)
      report_field("saturated", 32'(want.saturated), 32'(saturated));
    if (no_minus !== want.no_minus)
      report_field("no_minus", 32'(want.no_minus), 32'(no_minus));
    if (unit_range !== want.unit_range)
      report_field("unit_range", 32'(want.unit_range), 32'(unit_range));
    if (byte_value !== want.byte_value)
      report_field("byte_value", 32'(want.byte_value), 32'(byte_value));
    wf_seen   += int'(want.well_formed);
    sat_seen  += int'(want.saturated);
    unit_seen += int'(want.unit_range);
    byte_seen += int'(want.byte_value);
  endtask

  // Result side: random stalls, one long hold-off, stall-free stretches
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT_RESULT) hold = LONG_HOLD;
      else hold = (results_seen % 32 < 6) ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      check_result();
    end
  end

  // Character side: directed table, then random literals
  initial begin
    int shape, n_int, gap, i;
    clear_literal();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_LEN; i++)
      offer_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, $urandom_range(0, 7),
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

    while (chars_sent < DIRECTED_LEN + RANDOM_ITEMS) begin
      lit_chars.delete();
      shape = $urandom_range(0, 99);
      if (shape < 88) begin
        // sign, integer digits, optional fraction
        case ($urandom_range(0, 3))
          0: lit_chars.push_back(dlf_pkg::CH_PLUS);
          1: lit_chars.push_back(dlf_pkg::CH_MINUS);
          default: ;
        endcase
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
        repeat (n_int)
          lit_chars.push_back(($urandom_range(0, 3) == 0)
                              ? dlf_pkg::CH_ZERO + 8'd1
                              : dlf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          lit_chars.push_back(dlf_pkg::CH_DOT);
          repeat ($urandom_range(1, 10))
            lit_chars.push_back(dlf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (lit_chars.size() == 0)
          lit_chars.push_back(dlf_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        // break some of them
        if (shape >= 76) begin
          case ($urandom_range(0, 4))
            0: lit_chars.push_back(dlf_pkg::CH_DOT);
            1: lit_chars.insert($urandom_range(0, lit_chars.size() - 1), dlf_pkg::CH_DOT);
            2: lit_chars.insert($urandom_range(0, lit_chars.size() - 1), CH_SPACE);
            3: lit_chars.insert($urandom_range(0, lit_chars.size() - 1),
                                $urandom_range(0, 1) ? dlf_pkg::CH_PLUS
                                                     : dlf_pkg::CH_MINUS);
            default: lit_chars.insert($urandom_range(0, lit_chars.size() - 1), 8'($urandom));
          endcase
        end
      end else begin
        // noise
        repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom));
      end

      // let the block drain completely once
      if (literals_sent == PAUSE_AT_LITERAL) begin
        char_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end

      for (i = 0; i < lit_chars.size(); i++) begin
        gap = (literals_sent % 40 < 8) ? 0 : $urandom_range(0, 7);
        offer_char(lit_chars[i], i == lit_chars.size() - 1, gap, 1'b0, NONE);
      end
    end

    char_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d characters in %0d literals; %0d results checked.",
             chars_sent, literals_sent, results_seen);
    $display("Expected results: %0d well formed, %0d saturated, %0d in unit range, %0d bytes.",
             wf_seen, sat_seen, unit_seen, byte_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ decimal_literal_to_fixed_unit.f @@
design/dlf_pkg.sv
design/dlf_accum.sv
design/dlf_result.sv
design/decimal_literal_to_fixed_unit.sv
tb/testbench.sv
